>>> rtl/ttb_pkg.sv
// shared types, constants and helpers of the triangle tangent basis block
`default_nettype none

package ttb_pkg;

  // vertex table geometry
  localparam int VERTEX_SLOTS = 256;
  localparam int SLOT_W       = $clog2(VERTEX_SLOTS);
  localparam int COORD_W      = 16;
  localparam int VTX_W        = 5 * COORD_W;
  localparam int UV_V_LSB     = 0;
  localparam int UV_U_LSB     = COORD_W;

  // arithmetic widths
  localparam int DELTA_W = COORD_W + 1;
  localparam int PROD_W  = 2 * DELTA_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int MAG_W   = ACC_W - 1;
  localparam int RES_W   = 32;

  // divider: quotient of (2 * |num| * 2^20) / |den|, one bit a step
  localparam int SCALE_SH = 21;
  localparam int Q_W      = 34;
  localparam int LOW_W    = Q_W - SCALE_SH;
  localparam int CNT_W    = $clog2(Q_W);

  localparam logic [RES_W-1:0] SAT_POS = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] SAT_NEG = {1'b1, {(RES_W-1){1'b0}}};

  // corner phase codes
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  // input function codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_CORNER = 1'b1;

  // shared multiply-accumulate command
  typedef struct packed {
    logic                      en;
    logic                      load;
    logic                      sub;
    logic signed [DELTA_W-1:0] a;
    logic signed [DELTA_W-1:0] b;
  } mac_op_t;

  // divider request and response
  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] num;
    logic signed [ACC_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [RES_W-1:0] quo;
  } div_rsp_t;

  // position axis of a stored vertex word, x first
  function automatic logic [COORD_W-1:0] pos_of(input logic [VTX_W-1:0] w,
                                                 input logic [1:0] axis);
    logic [COORD_W-1:0] r;
    unique case (axis)
      2'd0:    r = w[VTX_W-1 -: COORD_W];
      2'd1:    r = w[VTX_W-COORD_W-1 -: COORD_W];
      default: r = w[VTX_W-2*COORD_W-1 -: COORD_W];
    endcase
    return r;
  endfunction

  // exact difference of two signed coordinates
  function automatic logic signed [DELTA_W-1:0] delta(input logic [COORD_W-1:0] a,
                                                      input logic [COORD_W-1:0] b);
    logic signed [DELTA_W-1:0] r;
    r = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    return r;
  endfunction

  // magnitude of an accumulator value
  function automatic logic [MAG_W-1:0] mag(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-1:0] r;
    r = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
    return r[MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/ttb_mac.sv
// shared signed multiply-accumulate unit
`default_nettype none

module ttb_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ttb_pkg::mac_op_t                    op_i,
  output logic signed [ttb_pkg::ACC_W-1:0]    acc_o
);
  import ttb_pkg::*;

  logic signed [DELTA_W-1:0] a_s;
  logic signed [DELTA_W-1:0] b_s;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   base;
  logic signed [ACC_W-1:0]   acc_d, acc_q;

  // product of the two operands, sign extended
  assign a_s      = op_i.a;
  assign b_s      = op_i.b;
  assign prod     = a_s * b_s;
  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  // load starts a new sum, otherwise add or subtract into it
  always_comb begin
    base  = op_i.load ? '0 : acc_q;
    acc_d = acc_q;
    if (op_i.en) begin
      acc_d = op_i.sub ? base - prod_ext : base + prod_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

>>> rtl/ttb_div.sv
// shared restoring divider, rounded and saturated fixed-point quotient
`default_nettype none

module ttb_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttb_pkg::div_req_t req_i,
  output ttb_pkg::div_rsp_t rsp_o
);
  import ttb_pkg::*;

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_DONE = 3'b100
  } div_state_e;

  div_state_e       state_d, state_q;
  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic [MAG_W-1:0] rem_d, rem_q;
  logic [Q_W-1:0]   sh_d, sh_q;
  logic [MAG_W-1:0] b_d, b_q;
  logic             neg_d, neg_q;
  logic             sat_d, sat_q;

  logic [MAG_W-1:0] a_mag;
  logic [MAG_W-1:0] b_mag;
  logic [MAG_W-1:0] a_hi;
  logic [MAG_W:0]   trial;
  logic             ge;
  logic [Q_W:0]     q_inc;
  logic [Q_W-1:0]   q_rnd;
  logic [RES_W-1:0] quo;

  // operand magnitudes and the part of the dividend above the quotient bits
  assign a_mag = mag(req_i.num);
  assign b_mag = mag(req_i.den);
  assign a_hi  = a_mag >> LOW_W;

  // one quotient bit per cycle
  assign trial = {rem_q, sh_q[Q_W-1]};
  assign ge    = trial >= {1'b0, b_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    sh_d    = sh_q;
    b_d     = b_q;
    neg_d   = neg_q;
    sat_d   = sat_q;
    unique case (state_q)
      DV_IDLE: begin
        if (req_i.start) begin
          b_d   = b_mag;
          neg_d = req_i.num[ACC_W-1] ^ req_i.den[ACC_W-1];
          sat_d = a_hi >= b_mag;
          rem_d = a_hi;
          sh_d  = {a_mag[LOW_W-1:0], {SCALE_SH{1'b0}}};
          cnt_d = '0;
          state_d = (a_hi >= b_mag) ? DV_DONE : DV_RUN;
        end
      end
      DV_RUN: begin
        rem_d = ge ? MAG_W'(trial - {1'b0, b_q}) : trial[MAG_W-1:0];
        sh_d  = {sh_q[Q_W-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(Q_W-1)) begin
          state_d = DV_DONE;
        end
      end
      DV_DONE: begin
        state_d = DV_IDLE;
      end
      default: begin
        state_d = DV_IDLE;
      end
    endcase
  end

  // round half away from zero on the extra low bit, then saturate
  assign q_inc = {1'b0, sh_q} + 1'b1;
  assign q_rnd = q_inc[Q_W:1];

  always_comb begin
    if (sat_q) begin
      quo = neg_q ? SAT_NEG : SAT_POS;
    end else if (neg_q) begin
      quo = (q_rnd > Q_W'(SAT_NEG)) ? SAT_NEG : RES_W'(-q_rnd);
    end else begin
      quo = (q_rnd > Q_W'(SAT_POS)) ? SAT_POS : q_rnd[RES_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    b_q   <= b_d;
    neg_q <= neg_d;
    sat_q <= sat_d;
  end

  assign rsp_o.done = state_q == DV_DONE;
  assign rsp_o.quo  = quo;

endmodule

`default_nettype wire

>>> rtl/triangle_tangent_basis.sv
// top level: vertex table, corner grouping and the tangent basis sequencer
//
// Two valid/stall channels. An input transaction with func 0 writes one vertex
// slot (position and texture coordinate); with func 1 it submits a triangle
// corner index. Every third corner produces one output transaction carrying
// the tangent, the bitangent (signed Q11.20, saturated) and a degenerate flag
// that is set, with zero vectors, when the UV determinant is zero.
// Vertex writes and the first two corners do not stall the input. The third
// corner reads the three vertices from the table through its one read port
// (states RD0 to RD3), forms the determinant on the shared multiply-accumulate
// unit (DET0, DET1, DCHK), then per component runs the MAC states NUM0 and
// NUM1 and the shared divider, which makes one quotient bit a cycle; a
// degenerate triangle skips the components and goes straight to the output.
// in_stall_o stays high from the third corner until its result is loaded.
// The result sits in an output register; while out_stall_i holds it, vertex
// writes and corners are still taken, and a following triangle completes its
// arithmetic and then waits until the held result is taken.
// Reset clears the corner phase and the output valid; the vertex table is not
// cleared, and a corner must only refer to slots written since reset.
`default_nettype none

module triangle_tangent_basis (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       func_i,
  input  logic [ttb_pkg::SLOT_W-1:0] vertex_slot_i,
  input  logic signed [15:0]         pos_x_i,
  input  logic signed [15:0]         pos_y_i,
  input  logic signed [15:0]         pos_z_i,
  input  logic signed [15:0]         tex_u_i,
  input  logic signed [15:0]         tex_v_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [31:0]         tangent_x_o,
  output logic signed [31:0]         tangent_y_o,
  output logic signed [31:0]         tangent_z_o,
  output logic signed [31:0]         bitangent_x_o,
  output logic signed [31:0]         bitangent_y_o,
  output logic signed [31:0]         bitangent_z_o,
  output logic                       degenerate_o
);
  import ttb_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_RD0  = 13'b0000000000010,
    ST_RD1  = 13'b0000000000100,
    ST_RD2  = 13'b0000000001000,
    ST_RD3  = 13'b0000000010000,
    ST_DET0 = 13'b0000000100000,
    ST_DET1 = 13'b0000001000000,
    ST_DCHK = 13'b0000010000000,
    ST_NUM0 = 13'b0000100000000,
    ST_NUM1 = 13'b0001000000000,
    ST_DIVS = 13'b0010000000000,
    ST_DIVW = 13'b0100000000000,
    ST_EMIT = 13'b1000000000000
  } seq_state_e;

  seq_state_e state_d, state_q;

  logic [1:0]        phase_d, phase_q;
  logic [SLOT_W-1:0] c0_q, c1_q, c2_q;
  logic              half_d, half_q;
  logic [1:0]        axis_d, axis_q;
  logic              out_valid_d, out_valid_q;

  logic              in_acc;
  logic              out_free;

  // vertex table
  logic [VTX_W-1:0]  vtx_mem [VERTEX_SLOTS];
  logic [SLOT_W-1:0] rd_addr;
  logic [VTX_W-1:0]  rdata_q;

  // corner data and deltas
  logic [VTX_W-1:0]          v0_q;
  logic signed [DELTA_W-1:0] e1_q [3];
  logic signed [DELTA_W-1:0] e2_q [3];
  logic signed [DELTA_W-1:0] du1_q, dv1_q, du2_q, dv2_q;
  logic signed [ACC_W-1:0]   det_q;

  // results
  logic [RES_W-1:0] tan_q [3];
  logic [RES_W-1:0] bit_q [3];
  logic             deg_q;
  logic [RES_W-1:0] o_tan_q [3];
  logic [RES_W-1:0] o_bit_q [3];
  logic             o_deg_q;

  mac_op_t                 mac_op;
  logic signed [ACC_W-1:0] acc;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // table write and registered read
  always_ff @(posedge clk_i) begin
    if (in_acc && (func_i == FUNC_WRITE)) begin
      vtx_mem[vertex_slot_i] <= {pos_x_i, pos_y_i, pos_z_i, tex_u_i, tex_v_i};
    end
    rdata_q <= vtx_mem[rd_addr];
  end

  always_comb begin
    case (state_q)
      ST_RD1:  rd_addr = c1_q;
      ST_RD2:  rd_addr = c2_q;
      default: rd_addr = c0_q;
    endcase
  end

  // operand selection for the shared multiply-accumulate unit
  always_comb begin
    mac_op      = '0;
    mac_op.en   = 1'b0;
    unique case (state_q)
      ST_DET0: begin
        mac_op.en   = 1'b1;
        mac_op.load = 1'b1;
        mac_op.a    = du1_q;
        mac_op.b    = dv2_q;
      end
      ST_DET1: begin
        mac_op.en  = 1'b1;
        mac_op.sub = 1'b1;
        mac_op.a   = dv1_q;
        mac_op.b   = du2_q;
      end
      ST_NUM0: begin
        mac_op.en   = 1'b1;
        mac_op.load = 1'b1;
        mac_op.a    = half_q ? e2_q[axis_q] : e1_q[axis_q];
        mac_op.b    = half_q ? du1_q : dv2_q;
      end
      ST_NUM1: begin
        mac_op.en  = 1'b1;
        mac_op.sub = 1'b1;
        mac_op.a   = half_q ? e1_q[axis_q] : e2_q[axis_q];
        mac_op.b   = half_q ? du2_q : dv1_q;
      end
      default: begin
        mac_op.en = 1'b0;
      end
    endcase
  end

  assign div_req.start = state_q == ST_DIVS;
  assign div_req.num   = acc;
  assign div_req.den   = det_q;

  ttb_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .acc_o  (acc)
  );

  ttb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    half_d      = half_q;
    axis_d      = axis_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (func_i == FUNC_CORNER)) begin
          if (phase_q == PH_SECOND) begin
            phase_d = PH_THIRD;
          end else if (phase_q == PH_THIRD) begin
            phase_d = PH_FIRST;
            state_d = ST_RD0;
          end else begin
            phase_d = PH_SECOND;
          end
        end
      end
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_RD3;
      ST_RD3:  state_d = ST_DET0;
      ST_DET0: state_d = ST_DET1;
      ST_DET1: state_d = ST_DCHK;
      ST_DCHK: begin
        half_d  = 1'b0;
        axis_d  = '0;
        state_d = (acc == '0) ? ST_EMIT : ST_NUM0;
      end
      ST_NUM0: state_d = ST_NUM1;
      ST_NUM1: state_d = ST_DIVS;
      ST_DIVS: state_d = ST_DIVW;
      ST_DIVW: begin
        if (div_rsp.done) begin
          if (axis_q == 2'd2) begin
            axis_d = '0;
            if (half_q) begin
              state_d = ST_EMIT;
            end else begin
              half_d  = 1'b1;
              state_d = ST_NUM0;
            end
          end else begin
            axis_d  = axis_q + 1'b1;
            state_d = ST_NUM0;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FIRST;
      c0_q        <= '0;
      c1_q        <= '0;
      half_q      <= 1'b0;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      half_q      <= half_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
      if (in_acc && (func_i == FUNC_CORNER)) begin
        if (phase_q == PH_SECOND) begin
          c1_q <= vertex_slot_i;
        end else if (phase_q != PH_THIRD) begin
          c0_q <= vertex_slot_i;
        end
      end
    end
  end

  // third corner, deltas, determinant, per-component results and output registers
  always_ff @(posedge clk_i) begin
    if (in_acc && (func_i == FUNC_CORNER) && (phase_q == PH_THIRD)) begin
      c2_q <= vertex_slot_i;
    end
    if (state_q == ST_RD1) begin
      v0_q <= rdata_q;
    end
    if (state_q == ST_RD2) begin
      for (int j = 0; j < 3; j++) begin
        e1_q[j] <= delta(pos_of(rdata_q, 2'(j)), pos_of(v0_q, 2'(j)));
      end
      du1_q <= delta(rdata_q[UV_U_LSB +: COORD_W], v0_q[UV_U_LSB +: COORD_W]);
      dv1_q <= delta(rdata_q[UV_V_LSB +: COORD_W], v0_q[UV_V_LSB +: COORD_W]);
    end
    if (state_q == ST_RD3) begin
      for (int j = 0; j < 3; j++) begin
        e2_q[j] <= delta(pos_of(rdata_q, 2'(j)), pos_of(v0_q, 2'(j)));
      end
      du2_q <= delta(rdata_q[UV_U_LSB +: COORD_W], v0_q[UV_U_LSB +: COORD_W]);
      dv2_q <= delta(rdata_q[UV_V_LSB +: COORD_W], v0_q[UV_V_LSB +: COORD_W]);
    end
    if (state_q == ST_DCHK) begin
      det_q <= acc;
      deg_q <= acc == '0;
      for (int j = 0; j < 3; j++) begin
        tan_q[j] <= '0;
        bit_q[j] <= '0;
      end
    end
    if ((state_q == ST_DIVW) && div_rsp.done) begin
      if (half_q) begin
        bit_q[axis_q] <= div_rsp.quo;
      end else begin
        tan_q[axis_q] <= div_rsp.quo;
      end
    end
    if ((state_q == ST_EMIT) && out_free) begin
      for (int j = 0; j < 3; j++) begin
        o_tan_q[j] <= tan_q[j];
        o_bit_q[j] <= bit_q[j];
      end
      o_deg_q <= deg_q;
    end
  end

  // output transaction
  assign out_valid_o   = out_valid_q;
  assign tangent_x_o   = o_tan_q[0];
  assign tangent_y_o   = o_tan_q[1];
  assign tangent_z_o   = o_tan_q[2];
  assign bitangent_x_o = o_bit_q[0];
  assign bitangent_y_o = o_bit_q[1];
  assign bitangent_z_o = o_bit_q[2];
  assign degenerate_o  = o_deg_q;

  // a degenerate result carries zero vectors
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |->
      (tangent_x_o == 0 && tangent_y_o == 0 && tangent_z_o == 0 &&
       bitangent_x_o == 0 && bitangent_y_o == 0 && bitangent_z_o == 0))
    else $error("degenerate result with nonzero vector");

  // the divider is never started with a zero determinant
  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (det_q != '0))
    else $error("division started with zero determinant");

  // a quotient only arrives while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIVW))
    else $error("unexpected divider completion");

  // a new result is loaded only when the previous one has been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(o_deg_q)))
    else $error("held result lost or changed");

endmodule

`default_nettype wire
